// ----- rtl/dpt_pkg.sv -----
`timescale 1ns / 1ps
// shared types and codes for the dual pulse train generator
// no dependencies; every other file but dpt_out_if refers to this package by scoped names

package dpt_pkg;

    // default widths of the time and period count fields
    localparam int TIME_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 16;

    // item kind
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_CMD  = 1'b1;

    // output selection codes
    localparam logic [1:0] SEL_FLOAT = 2'd0;
    localparam logic [1:0] SEL_NEG   = 2'd1;
    localparam logic [1:0] SEL_POS   = 2'd2;
    localparam logic [1:0] SEL_BOTH  = 2'd3;

    // command action codes
    localparam logic [1:0] ACT_FORCE_LOW  = 2'd0;
    localparam logic [1:0] ACT_FORCE_HIGH = 2'd1;
    localparam logic [1:0] ACT_CONT       = 2'd2;
    localparam logic [1:0] ACT_COUNTED    = 2'd3;

    // per-item control from the command decoder to one channel
    typedef struct packed {
        logic       tick;
        logic       stop;
        logic       load;
        logic [1:0] action;
    } chan_ctl_t;

    // status from one channel back to the pin logic and the result register
    typedef struct packed {
        logic level_wr;
        logic level;
        logic active_next;
    } chan_stat_t;

endpackage

// ----- rtl/dpt_in_if.sv -----
`timescale 1ns / 1ps
// input channel: tick and command items with valid/ready handshake
// depends on dpt_pkg for default field widths

interface dpt_in_if #(
    parameter int TIME_BITS  = dpt_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = dpt_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  mode;
    logic [1:0]            out_select;
    logic [1:0]            action;
    logic [TIME_BITS-1:0]  high_ticks;
    logic [TIME_BITS-1:0]  low_ticks;
    logic [COUNT_BITS-1:0] pulse_count;

    modport source (
        output valid, mode, out_select, action, high_ticks, low_ticks, pulse_count,
        input  ready
    );

    modport sink (
        input  valid, mode, out_select, action, high_ticks, low_ticks, pulse_count,
        output ready
    );
endinterface

// ----- rtl/dpt_out_if.sv -----
`timescale 1ns / 1ps
// result channel: pin levels and running flags with valid/ready handshake
// no dependencies

interface dpt_out_if;
    logic valid;
    logic ready;
    logic pos_level;
    logic neg_level;
    logic pos_running;
    logic neg_running;

    modport source (
        output valid, pos_level, neg_level, pos_running, neg_running,
        input  ready
    );

    modport sink (
        input  valid, pos_level, neg_level, pos_running, neg_running,
        output ready
    );
endinterface

// ----- rtl/dpt_chan.sv -----
`timescale 1ns / 1ps
// one pulse train channel: phase counter, period compare and counted stop
// depends on dpt_pkg for the control and status structs and action codes

module dpt_chan #(
    parameter int TIME_BITS  = dpt_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = dpt_pkg::COUNT_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dpt_pkg::chan_ctl_t     ctl,
    input  logic [TIME_BITS-1:0]   high_ticks,
    input  logic [TIME_BITS-1:0]   low_ticks,
    input  logic [COUNT_BITS-1:0]  pulse_count,
    output dpt_pkg::chan_stat_t    stat
);

    localparam logic [1:0] RUN_IDLE    = 2'd0;
    localparam logic [1:0] RUN_CONT    = 2'd1;
    localparam logic [1:0] RUN_COUNTED = 2'd2;

    logic [TIME_BITS:0]    phase_reg,  phase_next;
    logic [TIME_BITS-1:0]  high_reg,   high_next;
    logic [TIME_BITS-1:0]  low_reg,    low_next;
    logic [COUNT_BITS-1:0] target_reg, target_next;
    logic [COUNT_BITS-1:0] done_reg,   done_next;
    logic [1:0]            run_reg,    run_next;

    logic [TIME_BITS:0]    period;
    logic [TIME_BITS:0]    phase_inc;
    logic                  wrap;
    logic [COUNT_BITS-1:0] done_tick;
    logic                  counted;

    // period arithmetic on the current state
    assign period    = {1'b0, high_reg} + {1'b0, low_reg};
    assign phase_inc = phase_reg + {{TIME_BITS{1'b0}}, 1'b1};
    assign wrap      = (phase_inc >= period);
    assign counted   = (run_reg == RUN_COUNTED);
    assign done_tick = (wrap && counted) ? done_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1}
                                         : done_reg;

    // level for this tick, taken from the phase before it advances
    assign stat.level_wr    = (run_reg != RUN_IDLE) && (phase_reg < period);
    assign stat.level       = (phase_reg < {1'b0, high_reg});
    assign stat.active_next = (run_next != RUN_IDLE);

    // next state: stop, load or tick
    always_comb
    begin
        phase_next  = phase_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        target_next = target_reg;
        done_next   = done_reg;
        run_next    = run_reg;
        if (ctl.stop)
        begin
            phase_next  = '0;
            high_next   = '0;
            low_next    = '0;
            target_next = '0;
            done_next   = '0;
            run_next    = RUN_IDLE;
        end
        else if (ctl.load)
        begin
            phase_next  = '0;
            done_next   = '0;
            high_next   = high_ticks;
            low_next    = low_ticks;
            target_next = pulse_count;
            run_next    = RUN_IDLE;
            if (high_ticks != '0)
            begin
                if (ctl.action == dpt_pkg::ACT_CONT && pulse_count == '0)
                begin
                    run_next = RUN_CONT;
                end
                else if (ctl.action == dpt_pkg::ACT_COUNTED && pulse_count != '0)
                begin
                    run_next = RUN_COUNTED;
                end
            end
        end
        else if (ctl.tick && run_reg != RUN_IDLE)
        begin
            phase_next = wrap ? '0 : phase_inc;
            done_next  = done_tick;
            if (counted && done_tick >= target_reg)
            begin
                phase_next  = '0;
                high_next   = '0;
                low_next    = '0;
                target_next = '0;
                done_next   = '0;
                run_next    = RUN_IDLE;
            end
        end
    end

    // channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
            target_reg <= '0;
            done_reg   <= '0;
            run_reg    <= RUN_IDLE;
        end
        else
        begin
            phase_reg  <= phase_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            target_reg <= target_next;
            done_reg   <= done_next;
            run_reg    <= run_next;
        end
    end

endmodule

// ----- rtl/dual_pulse_train_generator.sv -----
`timescale 1ns / 1ps
// dual pulse train generator top level: command decode, pin register, result register
// depends on dpt_pkg, dpt_in_if, dpt_out_if and dpt_chan
//
// usage:
//   item   - sink channel of tick items (mode 0) and command items (mode 1);
//            a tick ignores every field but mode
//   result - source channel, one transfer per item: both pin levels and the
//            running flags of both channels as they stand after that item
//   timing: the result of an item is valid in the cycle after its transfer
//   throughput: one item per cycle while item.ready is high; each item is one
//            pass through the phase add and period compare of each channel
//            between the channel registers and the result register
//   stall: the result register holds its transfer while result.ready is low;
//            item.ready is high whenever the result register is empty or is
//            being taken in the same cycle, so a taken result and a new item
//            pass in one cycle
//   reset: both channels idle with times and counts cleared, pins low, outputs
//            not joined, no result pending

module dual_pulse_train_generator #(
    parameter int TIME_BITS  = dpt_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = dpt_pkg::COUNT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dpt_in_if.sink    item,
    dpt_out_if.source result
);

    logic                accept;
    logic                is_cmd;
    logic                is_force;
    logic                do_pos;
    logic                do_neg;
    logic                sel_float;

    dpt_pkg::chan_ctl_t  pos_ctl, neg_ctl;
    dpt_pkg::chan_stat_t pos_stat, neg_stat;

    logic       joined_reg, joined_next;
    logic [1:0] pin_reg,    pin_next;
    logic       out_valid_reg;
    logic       pos_level_reg, neg_level_reg, pos_running_reg, neg_running_reg;

    // handshake on the input side
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    // command decode
    assign is_cmd    = (item.mode == dpt_pkg::MODE_CMD);
    assign sel_float = (item.out_select == dpt_pkg::SEL_FLOAT);
    assign do_pos    = (item.out_select == dpt_pkg::SEL_BOTH)
                    || (item.out_select == dpt_pkg::SEL_POS);
    assign do_neg    = (item.out_select == dpt_pkg::SEL_BOTH)
                    || (item.out_select == dpt_pkg::SEL_NEG);
    assign is_force  = (item.action == dpt_pkg::ACT_FORCE_LOW)
                    || (item.action == dpt_pkg::ACT_FORCE_HIGH);

    // per-channel control
    always_comb
    begin
        pos_ctl.tick   = accept && !is_cmd;
        pos_ctl.stop   = accept && is_cmd && (sel_float || (is_force && do_pos));
        pos_ctl.load   = accept && is_cmd && !sel_float && !is_force && do_pos;
        pos_ctl.action = item.action;
        neg_ctl.tick   = accept && !is_cmd;
        neg_ctl.stop   = accept && is_cmd && (sel_float || (is_force && do_neg));
        neg_ctl.load   = accept && is_cmd && !sel_float && !is_force && do_neg;
        neg_ctl.action = item.action;
    end

    dpt_chan #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_pos_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (pos_ctl),
        .high_ticks  (item.high_ticks),
        .low_ticks   (item.low_ticks),
        .pulse_count (item.pulse_count),
        .stat        (pos_stat)
    );

    dpt_chan #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_neg_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (neg_ctl),
        .high_ticks  (item.high_ticks),
        .low_ticks   (item.low_ticks),
        .pulse_count (item.pulse_count),
        .stat        (neg_stat)
    );

    // pin levels and join flag
    always_comb
    begin
        pin_next    = pin_reg;
        joined_next = joined_reg;
        if (accept && is_cmd)
        begin
            if (sel_float)
            begin
                pin_next    = 2'b00;
                joined_next = 1'b0;
            end
            else if (is_force)
            begin
                if (do_pos)
                begin
                    pin_next[0] = item.action[0];
                end
                if (do_neg)
                begin
                    pin_next[1] = item.action[0];
                end
                joined_next = 1'b0;
            end
            else
            begin
                joined_next = (item.out_select == dpt_pkg::SEL_BOTH);
            end
        end
        else if (accept)
        begin
            if (pos_stat.level_wr)
            begin
                pin_next[0] = pos_stat.level;
                if (joined_reg)
                begin
                    pin_next[1] = pos_stat.level;
                end
            end
            if (neg_stat.level_wr && !joined_reg)
            begin
                pin_next[1] = neg_stat.level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_reg    <= 2'b00;
            joined_reg <= 1'b0;
        end
        else
        begin
            pin_reg    <= pin_next;
            joined_reg <= joined_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_level_reg   <= pin_next[0];
            neg_level_reg   <= pin_next[1];
            pos_running_reg <= pos_stat.active_next;
            neg_running_reg <= neg_stat.active_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pos_level   = pos_level_reg;
    assign result.neg_level   = neg_level_reg;
    assign result.pos_running = pos_running_reg;
    assign result.neg_running = neg_running_reg;

`ifndef SYNTH
    // a float command drops both pins
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_cmd && sel_float |=> pin_reg == 2'b00)
        else $error("float command left a pin high");

    // every transfer in produces a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    // the reported levels match the pin register right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pos_level_reg == pin_reg[0]) && (neg_level_reg == pin_reg[1]))
        else $error("result levels differ from pin register");

    // a joined pair ticks both pins to the same level
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_cmd && joined_reg && pos_stat.level_wr |=> pin_reg[0] == pin_reg[1])
        else $error("joined pins diverged on a tick");
`endif

endmodule

// ----- tb/dual_pulse_train_generator_tb.sv -----
`timescale 1ns / 1ps
// testbench for dual_pulse_train_generator: directed and random tick/command transfers
// checked against a cycle-free model of both channels and the pins
// depends on dpt_pkg, dpt_in_if, dpt_out_if and the generator rtl

module dual_pulse_train_generator_tb;

    localparam int TW              = dpt_pkg::TIME_BITS_DEF;
    localparam int CW              = dpt_pkg::COUNT_BITS_DEF;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_CYCLES     = 60;
    localparam int SETTLE_CYCLES   = 4;
    localparam int REPORT_LIMIT    = 100;

    // one item as it crosses the input channel
    typedef struct packed {
        logic          mode;
        logic [1:0]    out_select;
        logic [1:0]    action;
        logic [TW-1:0] high_ticks;
        logic [TW-1:0] low_ticks;
        logic [CW-1:0] pulse_count;
    } pulse_cmd_t;

    // one result as it crosses the output channel
    typedef struct packed {
        logic pos_level;
        logic neg_level;
        logic pos_running;
        logic neg_running;
    } pin_status_t;

    typedef enum logic [1:0] {
        TRAIN_IDLE,
        TRAIN_FREE,
        TRAIN_COUNTED
    } train_kind_t;

    // shadow copy of one channel
    typedef struct {
        logic [TW:0]   phase;
        logic [TW-1:0] high_t;
        logic [TW-1:0] low_t;
        logic [CW-1:0] target;
        logic [CW-1:0] done;
        train_kind_t   kind;
    } train_t;

    // predicts pin levels and running flags, and checks results in order
    class pulse_scoreboard;
        train_t      pos_tr;
        train_t      neg_tr;
        bit          joined;
        bit [1:0]    pins;
        pin_status_t expected_q[$];
        int          mismatches;
        int          n_cmds;
        int          n_ticks;
        int          n_checked;
        int          n_trains_ended;

        function new();
            pos_tr         = idle_train();
            neg_tr         = idle_train();
            joined         = 1'b0;
            pins           = 2'b00;
            mismatches     = 0;
            n_cmds         = 0;
            n_ticks        = 0;
            n_checked      = 0;
            n_trains_ended = 0;
        endfunction

        function train_t idle_train();
            train_t t;
            t.phase  = '0;
            t.high_t = '0;
            t.low_t  = '0;
            t.target = '0;
            t.done   = '0;
            t.kind   = TRAIN_IDLE;
            return t;
        endfunction

        // a train only starts with a nonzero high time and a count that fits the action
        function train_t load_train(logic [1:0] act, logic [TW-1:0] hi, logic [TW-1:0] lo,
                                    logic [CW-1:0] cnt);
            train_t t;
            t        = idle_train();
            t.high_t = hi;
            t.low_t  = lo;
            t.target = cnt;
            if (hi != 0)
            begin
                if (act == dpt_pkg::ACT_CONT && cnt == 0)
                    t.kind = TRAIN_FREE;
                if (act == dpt_pkg::ACT_COUNTED && cnt != 0)
                    t.kind = TRAIN_COUNTED;
            end
            return t;
        endfunction

        // one tick of a channel; returns whether the channel writes its pin
        function bit advance_train(inout train_t t, output bit level);
            logic [TW:0] period;
            bit          writes;
            writes = 1'b0;
            level  = 1'b0;
            if (t.kind == TRAIN_IDLE)
                return 1'b0;
            period = {1'b0, t.high_t} + {1'b0, t.low_t};
            if (t.phase < {1'b0, t.high_t})
            begin
                writes = 1'b1;
                level  = 1'b1;
            end
            else if (t.phase < period)
            begin
                writes = 1'b1;
                level  = 1'b0;
            end
            t.phase = t.phase + 1'b1;
            // wrap at the end of the period, counting periods in counted mode
            if (t.phase >= period)
            begin
                t.phase = '0;
                if (t.kind == TRAIN_COUNTED)
                    t.done = t.done + 1'b1;
            end
            if (t.kind == TRAIN_COUNTED && t.done >= t.target)
            begin
                t = idle_train();
                n_trains_ended++;
            end
            return writes;
        endfunction

        function void note_item(pulse_cmd_t c);
            bit          do_pos;
            bit          do_neg;
            bit          lvl;
            bit          lvl_p;
            bit          lvl_n;
            bit          wr_p;
            bit          wr_n;
            pin_status_t exp;
            if (c.mode == dpt_pkg::MODE_CMD)
            begin
                n_cmds++;
                do_pos = (c.out_select == dpt_pkg::SEL_BOTH
                          || c.out_select == dpt_pkg::SEL_POS);
                do_neg = (c.out_select == dpt_pkg::SEL_BOTH
                          || c.out_select == dpt_pkg::SEL_NEG);
                // float: everything stops and both pins drop
                if (c.out_select == dpt_pkg::SEL_FLOAT)
                begin
                    pos_tr = idle_train();
                    neg_tr = idle_train();
                    joined = 1'b0;
                    pins   = 2'b00;
                end
                else if (c.action == dpt_pkg::ACT_FORCE_LOW
                         || c.action == dpt_pkg::ACT_FORCE_HIGH)
                begin
                    lvl = (c.action == dpt_pkg::ACT_FORCE_HIGH);
                    if (do_pos)
                    begin
                        pos_tr  = idle_train();
                        pins[0] = lvl;
                    end
                    if (do_neg)
                    begin
                        neg_tr  = idle_train();
                        pins[1] = lvl;
                    end
                    joined = 1'b0;
                end
                else
                begin
                    joined = (c.out_select == dpt_pkg::SEL_BOTH);
                    if (do_pos)
                        pos_tr = load_train(c.action, c.high_ticks, c.low_ticks, c.pulse_count);
                    if (do_neg)
                        neg_tr = load_train(c.action, c.high_ticks, c.low_ticks, c.pulse_count);
                end
            end
            else
            begin
                n_ticks++;
                wr_p = advance_train(pos_tr, lvl_p);
                wr_n = advance_train(neg_tr, lvl_n);
                // when joined the positive channel drives both pins
                if (wr_p)
                begin
                    pins[0] = lvl_p;
                    if (joined)
                        pins[1] = lvl_p;
                end
                if (wr_n && !joined)
                    pins[1] = lvl_n;
            end
            exp.pos_level   = pins[0];
            exp.neg_level   = pins[1];
            exp.pos_running = (pos_tr.kind != TRAIN_IDLE);
            exp.neg_running = (neg_tr.kind != TRAIN_IDLE);
            expected_q.push_back(exp);
        endfunction

        function void report(string what);
            if (mismatches < REPORT_LIMIT)
                $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endfunction

        function void check_field(string name, logic got, logic exp);
            if (got !== exp)
                report($sformatf("result %0d %s got %b expected %b", n_checked, name, got, exp));
        endfunction

        function void check_result(pin_status_t got);
            pin_status_t exp;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing pending", n_checked));
                n_checked++;
                return;
            end
            exp = expected_q.pop_front();
            check_field("pos_level", got.pos_level, exp.pos_level);
            check_field("neg_level", got.neg_level, exp.neg_level);
            check_field("pos_running", got.pos_running, exp.pos_running);
            check_field("neg_running", got.neg_running, exp.neg_running);
            n_checked++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dpt_in_if #(.TIME_BITS(TW), .COUNT_BITS(CW)) item_if ();
    dpt_out_if result_if ();

    dual_pulse_train_generator #(
        .TIME_BITS  (TW),
        .COUNT_BITS (CW)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .result (result_if)
    );

    pulse_scoreboard sb = new();

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int items_sent;
    int idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // result side: random ready, with a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                result_if.ready <= 1'b0;
                hold_left--;
            end
            else
                result_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        pulse_cmd_t  seen;
        pin_status_t got;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got = {result_if.pos_level, result_if.neg_level,
                       result_if.pos_running, result_if.neg_running};
                sb.check_result(got);
            end
            if (item_if.valid && item_if.ready)
            begin
                seen = {item_if.mode, item_if.out_select, item_if.action,
                        item_if.high_ticks, item_if.low_ticks, item_if.pulse_count};
                sb.note_item(seen);
            end
            if ((result_if.valid && result_if.ready) || (item_if.valid && item_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_CYCLES);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic pulse_cmd_t make_cmd(logic [1:0] sel, logic [1:0] act,
                                            logic [TW-1:0] hi, logic [TW-1:0] lo,
                                            logic [CW-1:0] cnt);
        pulse_cmd_t c;
        c.mode        = dpt_pkg::MODE_CMD;
        c.out_select  = sel;
        c.action      = act;
        c.high_ticks  = hi;
        c.low_ticks   = lo;
        c.pulse_count = cnt;
        return c;
    endfunction

    // a tick carries random don't-care fields
    function automatic pulse_cmd_t random_tick();
        pulse_cmd_t c;
        c.mode        = dpt_pkg::MODE_TICK;
        c.out_select  = 2'($urandom);
        c.action      = 2'($urandom);
        c.high_ticks  = TW'($urandom);
        c.low_ticks   = TW'($urandom);
        c.pulse_count = CW'($urandom);
        return c;
    endfunction

    // mostly short times so trains finish, sometimes zero or huge
    function automatic logic [TW-1:0] random_time();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 4)
            return '0;
        if (roll < 92)
            return TW'($urandom_range(1, 6));
        if (roll < 96)
            return TW'($urandom);
        return '1;
    endfunction

    function automatic logic [CW-1:0] random_count(logic [1:0] act);
        int roll;
        roll = $urandom_range(0, 99);
        if (act == dpt_pkg::ACT_COUNTED)
        begin
            if (roll < 85)
                return CW'($urandom_range(1, 5));
            if (roll < 90)
                return '0;
            return CW'($urandom);
        end
        if (roll < 80)
            return '0;
        return CW'($urandom);
    endfunction

    function automatic pulse_cmd_t random_command();
        pulse_cmd_t c;
        int         roll;
        c       = random_tick();
        c.mode  = dpt_pkg::MODE_CMD;
        // a few commands keep fully random fields
        if ($urandom_range(0, 99) < 8)
            return c;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            c.action = dpt_pkg::ACT_FORCE_LOW;
        else if (roll < 30)
            c.action = dpt_pkg::ACT_FORCE_HIGH;
        else if (roll < 60)
            c.action = dpt_pkg::ACT_CONT;
        else
            c.action = dpt_pkg::ACT_COUNTED;
        c.high_ticks  = random_time();
        c.low_ticks   = random_time();
        c.pulse_count = random_count(c.action);
        return c;
    endfunction

    // offer one item, with random idle cycles first, and wait for its transfer
    task automatic send_item(pulse_cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        item_if.valid       <= 1'b1;
        item_if.mode        <= c.mode;
        item_if.out_select  <= c.out_select;
        item_if.action      <= c.action;
        item_if.high_ticks  <= c.high_ticks;
        item_if.low_ticks   <= c.low_ticks;
        item_if.pulse_count <= c.pulse_count;
        do
            @(posedge clk);
        while (!item_if.ready);
        items_sent++;
    endtask

    // sender pauses until every result is back
    task automatic wait_for_results();
        @(negedge clk);
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_item(random_tick());
        send_item(make_cmd(dpt_pkg::SEL_BOTH, dpt_pkg::ACT_FORCE_HIGH, '0, '0, '0));
        // float ignores the action and the other fields
        send_item(make_cmd(dpt_pkg::SEL_FLOAT, dpt_pkg::ACT_COUNTED, '1, '1, '1));
        send_item(make_cmd(dpt_pkg::SEL_POS, dpt_pkg::ACT_FORCE_HIGH, '0, '0, '0));
        send_item(make_cmd(dpt_pkg::SEL_NEG, dpt_pkg::ACT_FORCE_HIGH, '0, '0, '0));
        send_item(make_cmd(dpt_pkg::SEL_POS, dpt_pkg::ACT_FORCE_LOW, '1, '1, '1));
        // continuous with a count, counted with no count, zero high time: no start
        send_item(make_cmd(dpt_pkg::SEL_POS, dpt_pkg::ACT_CONT, TW'(2), TW'(2), CW'(5)));
        send_item(make_cmd(dpt_pkg::SEL_NEG, dpt_pkg::ACT_COUNTED, TW'(1), TW'(1), '0));
        send_item(make_cmd(dpt_pkg::SEL_BOTH, dpt_pkg::ACT_CONT, '0, TW'(3), '0));
        // zero low time keeps the pin high
        send_item(make_cmd(dpt_pkg::SEL_POS, dpt_pkg::ACT_CONT, TW'(1), '0, '0));
        send_item(random_tick());
        send_item(random_tick());
        // joined counted train of two periods runs out
        send_item(make_cmd(dpt_pkg::SEL_BOTH, dpt_pkg::ACT_COUNTED, TW'(1), TW'(1), CW'(2)));
        repeat (5)
            send_item(random_tick());
        send_item(make_cmd(dpt_pkg::SEL_NEG, dpt_pkg::ACT_COUNTED, '1, '1, '1));
        send_item(random_tick());
        send_item(make_cmd(dpt_pkg::SEL_NEG, dpt_pkg::ACT_CONT, TW'(2), TW'(1), '0));
        send_item(random_tick());
        send_item(make_cmd(dpt_pkg::SEL_FLOAT, dpt_pkg::ACT_FORCE_HIGH, '0, '0, '0));
        wait_for_results();
    endtask

    // command followed by a burst of ticks
    task automatic send_sequence();
        int n_ticks;
        send_item(random_command());
        n_ticks = $urandom_range(0, 24);
        repeat (n_ticks)
            send_item(random_tick());
    endtask

    task automatic run_random(int send_pct, int recv_pct, int n_items, bit with_hold);
        int  start_count;
        bit  held;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = items_sent;
        held          = 1'b0;
        while (items_sent - start_count < n_items)
        begin
            // stall the result side while items keep coming
            if (with_hold && !held && items_sent - start_count >= n_items / 2)
            begin
                hold_request = 1'b1;
                held         = 1'b1;
            end
            send_sequence();
        end
        wait_for_results();
    endtask

    // stimulus and final verdict
    initial
    begin
        rst_n               = 1'b0;
        item_if.valid       = 1'b0;
        item_if.mode        = dpt_pkg::MODE_TICK;
        item_if.out_select  = dpt_pkg::SEL_FLOAT;
        item_if.action      = dpt_pkg::ACT_FORCE_LOW;
        item_if.high_ticks  = '0;
        item_if.low_ticks   = '0;
        item_if.pulse_count = '0;
        send_idle_pct       = 18;
        recv_idle_pct       = 68;
        hold_request        = 1'b0;
        items_sent          = 0;
        idle_cycles         = 0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(18, 68, 470, 1'b1);
        run_random(68, 18, 470, 1'b0);
        run_random(0, 0, 440, 1'b1);

        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        $display("covered %0d commands and %0d ticks under three ready/valid idling patterns",
                 sb.n_cmds, sb.n_ticks);
        $display("%0d results checked, %0d counted trains ran to their end",
                 sb.n_checked, sb.n_trains_ended);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dpt_pkg.sv
rtl/dpt_in_if.sv
rtl/dpt_out_if.sv
rtl/dpt_chan.sv
rtl/dual_pulse_train_generator.sv
tb/dual_pulse_train_generator_tb.sv
